// File: rtl/kth_pkg.sv
// ----------------------------------------------------------------------------
// kth_pkg
// Shared constants, codes and control types of the keyed table CRC id hash.
// ----------------------------------------------------------------------------
package kth_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableIdxW  = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned MaxDigits  = 10;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned DigitIdxW  = $clog2(MaxDigits);
  localparam int unsigned DigitCntW  = $clog2(MaxDigits + 1);

  localparam logic [WordW-1:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] CrcXorOut = 32'hFFFF_FFFF;

  // q = (v * DivMagic) >> DivShift equals v / 10 for every 32-bit v
  localparam logic [WordW-1:0] DivMagic = 32'hCCCC_CCCD;
  localparam int unsigned      DivShift = 35;

  // upper nibble of an ascii decimal digit
  localparam logic [3:0] AsciiDigitHi = 4'h3;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncHash  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_PRIME = 4'b0100,
    S_CRC   = 4'b1000
  } kth_state_t;

  typedef struct packed {
    logic load;      // take a hash item
    logic div_step;  // peel one decimal digit
    logic rd_issue;  // start a key table read for the next digit
    logic crc_upd;   // fold the table word into the crc
    logic finish;    // last crc step, present the result
  } kth_cmd_t;

  typedef struct packed {
    logic div_last;   // this digit is the most significant one
    logic none_left;  // every digit has had its table read issued
  } kth_sts_t;

endpackage

// File: rtl/kth_ctrl.sv
// ----------------------------------------------------------------------------
// kth_ctrl
// Sequencer: digit extraction, table read priming and crc folding steps.
// ----------------------------------------------------------------------------
module kth_ctrl
  import kth_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_func,
  input  kth_sts_t sts,
  output kth_cmd_t cmd,
  output logic     busy
);

  kth_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start && (in_func == FuncHash)) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_CRC;
      end
      S_CRC: begin
        cmd.crc_upd = 1'b1;
        if (sts.none_left) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/kth_dp.sv
// ----------------------------------------------------------------------------
// kth_dp
// Datapath: key table memory, divide-by-ten digit stack and crc register.
// ----------------------------------------------------------------------------
module kth_dp
  import kth_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tbl_wr,
  input  logic [TableIdxW-1:0] in_table_index,
  input  logic [WordW-1:0]     in_table_word,
  input  logic [WordW-1:0]     in_account_id,
  input  kth_cmd_t             cmd,
  output kth_sts_t             sts,
  output logic                 out_valid,
  output logic [WordW-1:0]     out_hashed_id
);

  logic [WordW-1:0]     mem [TableDepth];
  logic [WordW-1:0]     rd_data_r;
  logic [TableIdxW-1:0] rd_addr;

  logic [WordW-1:0]     val_r;
  logic [DigitCntW-1:0] cnt_r;
  logic [DigitW-1:0]    digit_r [MaxDigits];
  logic [WordW-1:0]     crc_r;
  logic                 out_valid_r;
  logic [WordW-1:0]     out_hash_r;

  logic [2*WordW-1:0]   prod;
  logic [WordW-1:0]     quot;
  logic [WordW-1:0]     rem_full;
  logic [DigitIdxW-1:0] wr_idx;
  logic [DigitIdxW-1:0] rd_idx;
  logic [WordW-1:0]     crc_cur;

  // reciprocal multiply for the divide by ten
  assign prod     = {{WordW{1'b0}}, val_r} * {{WordW{1'b0}}, DivMagic};
  assign quot     = WordW'(prod >> DivShift);
  assign rem_full = val_r - ((quot << 3) + (quot << 1));

  assign wr_idx = cnt_r[DigitIdxW-1:0];
  assign rd_idx = DigitIdxW'(cnt_r - DigitCntW'(1));

  assign crc_cur = cmd.crc_upd ? (rd_data_r ^ (crc_r >> 8)) : crc_r;
  assign rd_addr = {AsciiDigitHi, digit_r[rd_idx]} ^ crc_cur[TableIdxW-1:0];

  assign sts.div_last  = (quot == '0) || (cnt_r == DigitCntW'(MaxDigits - 1));
  assign sts.none_left = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      mem[in_table_index] <= in_table_word;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + DigitCntW'(1);
    end else if (cmd.rd_issue) begin
      cnt_r <= cnt_r - DigitCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_account_id;
      crc_r <= CrcInit;
    end else begin
      if (cmd.div_step) begin
        val_r           <= quot;
        digit_r[wr_idx] <= rem_full[DigitW-1:0];
      end
      if (cmd.crc_upd) begin
        crc_r <= crc_cur;
      end
    end
    if (cmd.finish) begin
      out_hash_r <= crc_cur ^ CrcXorOut;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hashed_id = out_hash_r;

endmodule

// File: rtl/keyed_table_crc_id_hash_core.sv
// ----------------------------------------------------------------------------
// keyed_table_crc_id_hash_core
// Keyed table CRC over the decimal ascii digits of a 32-bit account number.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     start / busy         in_func, in_table_index, in_table_word,
//                                 in_account_id
//  result    out_valid (strobe)   out_hashed_id
//
//  a table write lands in the key table at the accepting edge
//  a hash of an n-digit number (n = 1..10) keeps busy high through
//  n divide-by-ten steps, one table read prime and n crc folds on the table port
//  out_valid pulses in the first cycle with busy low again; the receiver cannot stall
//  rst_n clears the sequencer and the strobe; the key table is not cleared
module keyed_table_crc_id_hash_core
  import kth_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic [TableIdxW-1:0] in_table_index,
  input  logic [WordW-1:0]     in_table_word,
  input  logic [WordW-1:0]     in_account_id,
  output logic                 out_valid,
  output logic [WordW-1:0]     out_hashed_id
);

  kth_cmd_t cmd;
  kth_sts_t sts;
  logic     tbl_wr;

  assign tbl_wr = start && !busy && (in_func == FuncWrite);

  kth_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  kth_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .tbl_wr         (tbl_wr),
    .in_table_index (in_table_index),
    .in_table_word  (in_table_word),
    .in_account_id  (in_account_id),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_hashed_id  (out_hashed_id)
  );

endmodule

// File: rtl/kth_chk.sv
// ----------------------------------------------------------------------------
// kth_chk
// Port-level checks of the keyed table CRC id hash, bound to the top level.
// ----------------------------------------------------------------------------
module kth_chk
  import kth_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             in_func,
  input logic             out_valid,
  input logic [WordW-1:0] out_hashed_id
);

  // a hash transfer occupies the block right away
  a_hash_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FuncHash)) |=> busy)
    else $error("hash transfer did not raise busy");

  // a table write completes in its own cycle
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FuncWrite)) |=> (!busy && !out_valid))
    else $error("table write made the block busy or gave a result");

  // a result comes only once the sequencer is back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // one strobe per hash
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // the result appears right after busy falls
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

  logic unused_hash;
  assign unused_hash = ^out_hashed_id;

endmodule

bind keyed_table_crc_id_hash_core kth_chk u_kth_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_hashed_id (out_hashed_id)
);

// File: bench/keyed_table_crc_id_hash_core_tb.sv
// ----------------------------------------------------------------------------
// keyed_table_crc_id_hash_core_tb
// Self-checking bench for the keyed table CRC id hash core. The key table is
// loaded first with the standard reflected CRC-32 table, then with random
// words. Hash items are predicted from a shadow copy of the table and
// compared with every out_valid strobe. Random bursts and gaps are applied
// on the start side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyed_table_crc_id_hash_core_tb;
  import kth_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MixedItems    = 1150;
  localparam int unsigned MaxPrinted    = 100;

  // shadow key table and the hash values still owed by the block
  class hash_tracker;
    logic [WordW-1:0] key_words [TableDepth];
    logic [WordW-1:0] owed_hashes [$];

    function automatic logic [WordW-1:0] digits_crc(logic [WordW-1:0] id);
      logic [7:0]       digits [MaxDigits];
      int               n;
      logic [WordW-1:0] v;
      logic [WordW-1:0] crc;
      v = id;
      n = 0;
      // least significant digit first, folded back to front below
      do begin
        digits[n] = 8'h30 + 8'(v % 10);
        v = v / 10;
        n++;
      end while (v != 0);
      crc = CrcInit;
      for (int i = n - 1; i >= 0; i--) begin
        crc = key_words[digits[i] ^ crc[7:0]] ^ (crc >> 8);
      end
      return crc ^ CrcXorOut;
    endfunction

    function automatic void note(logic func, logic [TableIdxW-1:0] idx,
                                 logic [WordW-1:0] word, logic [WordW-1:0] id);
      if (func == FuncWrite) begin
        key_words[idx] = word;
      end else begin
        owed_hashes.push_back(digits_crc(id));
      end
    endfunction

    function automatic bit check(logic [WordW-1:0] got, output string msg);
      logic [WordW-1:0] want;
      msg = "";
      if (owed_hashes.size() == 0) begin
        msg = $sformatf("hashed_id %08h with no hash outstanding", got);
        return 1'b0;
      end
      want = owed_hashes.pop_front();
      if (got !== want) begin
        msg = $sformatf("hashed_id %08h, want %08h", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function automatic int pending();
      return owed_hashes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic                 in_func        = FuncWrite;
  logic [TableIdxW-1:0] in_table_index = '0;
  logic [WordW-1:0]     in_table_word  = '0;
  logic [WordW-1:0]     in_account_id  = '0;
  logic                 out_valid;
  logic [WordW-1:0]     out_hashed_id;

  hash_tracker tracker;
  int          errors      = 0;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  bit          idle_on     = 1'b0;

  keyed_table_crc_id_hash_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_table_index (in_table_index),
    .in_table_word  (in_table_word),
    .in_account_id  (in_account_id),
    .out_valid      (out_valid),
    .out_hashed_id  (out_hashed_id)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string msg);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // called right after a rising edge; returns at the edge of the transfer
  task automatic send_item(logic func, logic [TableIdxW-1:0] idx,
                           logic [WordW-1:0] word, logic [WordW-1:0] id);
    start          <= 1'b1;
    in_func        <= func;
    in_table_index <= idx;
    in_table_word  <= word;
    in_account_id  <= id;
    do @(posedge clk); while (busy);
    tracker.note(func, idx, word, id);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start          <= 1'b0;
      in_func        <= 1'($urandom_range(0, 1));
      in_table_index <= TableIdxW'($urandom);
      in_table_word  <= $urandom;
      in_account_id  <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(logic func, logic [TableIdxW-1:0] idx,
                       logic [WordW-1:0] word, logic [WordW-1:0] id);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (idle_on) begin
        pause(($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6));
      end
    end
    send_item(func, idx, word, id);
    burst_left--;
  endtask

  function automatic logic [WordW-1:0] crc32_entry(int unsigned b);
    logic [WordW-1:0] c;
    c = b;
    repeat (8) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    return c;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TableIdxW-1:0] rand_idx();
    return TableIdxW'($urandom);
  endfunction

  function automatic logic [WordW-1:0] rand_account();
    int unsigned n;
    longint      lo;
    longint      hi;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 9);
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return '1;
          2:       return 32'd999_999_999;
          3:       return 32'd1_000_000_000;
          4:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: begin
        // uniform digit count so short and long numbers both show up
        n  = $urandom_range(1, MaxDigits);
        lo = 1;
        repeat (n - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return $urandom_range(32'(hi), 32'(lo));
      end
    endcase
  endfunction

  always @(posedge clk) begin : result_mon
    string msg;
    if (rst_n && out_valid) begin
      if (!tracker.check(out_hashed_id, msg)) report(msg);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("keyed_table_crc_id_hash_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // standard crc-32 table, back to back writes
    idle_on = 1'b0;
    for (int i = 0; i < TableDepth; i++) begin
      issue(FuncWrite, TableIdxW'(i), crc32_entry(i), $urandom);
    end

    // digit count boundaries and extremes of the account number
    issue(FuncHash, '0, '0, 32'd0);
    issue(FuncHash, '1, '1, 32'd1);
    issue(FuncHash, rand_idx(), $urandom, 32'd9);
    issue(FuncHash, rand_idx(), $urandom, 32'd10);
    issue(FuncHash, rand_idx(), $urandom, 32'd99);
    issue(FuncHash, rand_idx(), $urandom, 32'd100);
    issue(FuncHash, rand_idx(), $urandom, 32'd123_456_789);
    issue(FuncHash, rand_idx(), $urandom, 32'd999_999_999);
    issue(FuncHash, rand_idx(), $urandom, 32'd1_000_000_000);
    issue(FuncHash, rand_idx(), $urandom, 32'h7FFF_FFFF);
    issue(FuncHash, rand_idx(), $urandom, 32'h8000_0000);
    issue(FuncHash, rand_idx(), $urandom, 32'hFFFF_FFFF);
    // table writes with the ignored account field at both extremes
    issue(FuncWrite, '0, '0, '1);
    issue(FuncWrite, '1, '1, '0);
    issue(FuncWrite, 8'h55, 32'hAAAA_AAAA, '1);
    issue(FuncWrite, 8'hAA, 32'h5555_5555, '0);
    issue(FuncHash, rand_idx(), $urandom, 32'd0);
    issue(FuncHash, rand_idx(), $urandom, 32'hFFFF_FFFF);
    issue(FuncHash, rand_idx(), $urandom, 32'd5);
    issue(FuncHash, rand_idx(), $urandom, 32'd4_294_967_290);

    // random key table, written with idle gaps
    idle_on = 1'b1;
    for (int i = 0; i < TableDepth; i++) begin
      issue(FuncWrite, TableIdxW'(i), rand_word(), $urandom);
    end

    // mixed hashes and table rewrites, idling switched per stretch
    for (int i = 0; i < MixedItems; i++) begin
      if (i % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 3) begin
        issue(FuncWrite, rand_idx(), rand_word(), $urandom);
      end else begin
        issue(FuncHash, rand_idx(), $urandom, rand_account());
      end
    end

    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("keyed_table_crc_id_hash_core_tb: PASS");
    end else begin
      $display("keyed_table_crc_id_hash_core_tb: FAIL");
    end
    $finish;
  end

endmodule
